// ----- rtl/mpsr_pkg.sv -----
// Shared types, codes and reset values for the masked pattern stride run scanner.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package mpsr_pkg;

  localparam int PATTERN_MAX_DEFAULT = 32;
  localparam int ADDR_W = 47;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int COUNT_W = 12;

  // Item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_SCAN = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  // Finish outcomes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_RESOLVED = 2'd1;
  localparam logic [1:0] ST_UNRESOLVED = 2'd2;
  localparam logic [1:0] ST_AMBIGUOUS = 2'd3;

  // Register indexes (byte address 4 * index)
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_RUN_SPACING = 2'd1;
  localparam logic [1:0] REG_RUN_TARGET = 2'd2;
  localparam logic [1:0] REG_HIT_LIMIT = 2'd3;

  localparam logic [5:0] PATTERN_LENGTH_RESET = 6'd16;
  localparam logic [19:0] RUN_SPACING_RESET = 20'd16;
  localparam logic [10:0] RUN_TARGET_RESET = 11'd1;
  localparam logic [10:0] HIT_LIMIT_RESET = 11'd1024;

  typedef struct packed {
    logic [5:0] pattern_length;
    logic [19:0] run_spacing;
    logic [10:0] run_target;
    logic [10:0] hit_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] pattern_index;
    logic [7:0] data_byte;
    logic wildcard_req;
    logic [ADDR_W-1:0] byte_address;
    logic region_start;
  } item_t;

  typedef struct packed {
    logic hit;
    logic [ADDR_W-1:0] hit_address;
    logic [1:0] final_status;
    logic [ADDR_W-1:0] run_base;
  } result_t;

  // Between the match stage and the run stage
  typedef struct packed {
    logic [1:0] mode;
    logic match;
    logic [ADDR_W-1:0] start;
  } match_word_t;

endpackage

// ----- rtl/mpsr_cfg.sv -----
// Configuration register bank on an APB-style port.
// Depends on mpsr_pkg for the register struct, indexes and reset values.
`timescale 1ns / 1ps

module mpsr_cfg (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mpsr_pkg::PADDR_W-1:0] paddr,
  input  logic [mpsr_pkg::PDATA_W-1:0] pwdata,
  output logic [mpsr_pkg::PDATA_W-1:0] prdata,
  output logic pready,
  output mpsr_pkg::cfg_t cfg
);

  logic [1:0] index;

  assign index = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= mpsr_pkg::PATTERN_LENGTH_RESET;
      cfg.run_spacing <= mpsr_pkg::RUN_SPACING_RESET;
      cfg.run_target <= mpsr_pkg::RUN_TARGET_RESET;
      cfg.hit_limit <= mpsr_pkg::HIT_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (index)
        mpsr_pkg::REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[5:0];
        mpsr_pkg::REG_RUN_SPACING: cfg.run_spacing <= pwdata[19:0];
        mpsr_pkg::REG_RUN_TARGET: cfg.run_target <= pwdata[10:0];
        mpsr_pkg::REG_HIT_LIMIT: cfg.hit_limit <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      mpsr_pkg::REG_PATTERN_LENGTH: prdata = 32'(cfg.pattern_length);
      mpsr_pkg::REG_RUN_SPACING: prdata = 32'(cfg.run_spacing);
      mpsr_pkg::REG_RUN_TARGET: prdata = 32'(cfg.run_target);
      mpsr_pkg::REG_HIT_LIMIT: prdata = 32'(cfg.hit_limit);
      default: prdata = '0;
    endcase
  end

endmodule

// ----- rtl/mpsr_match.sv -----
// Pattern store, byte window and parallel masked compare; registers the match word.
// Depends on mpsr_pkg for the item, configuration and match word types.
`timescale 1ns / 1ps

module mpsr_match #(
  parameter int PATTERN_MAX = mpsr_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  mpsr_pkg::cfg_t cfg,
  input  logic take,
  input  mpsr_pkg::item_t item,
  output mpsr_pkg::match_word_t mid
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = $clog2(PATTERN_MAX);
  localparam int CMP_W = (LEN_W > 6) ? LEN_W : 6;
  localparam int WIN_W = 8 * PATTERN_MAX;

  logic [7:0] pat_value [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] pat_wild;
  logic [7:0] window [PATTERN_MAX];
  logic [7:0] window_next [PATTERN_MAX];
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] fill_next;
  logic [CMP_W-1:0] len_cfg;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] shamt;
  logic [WIN_W-1:0] rev;
  logic [WIN_W-1:0] aligned;
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] used;
  logic window_match;
  logic load_ok;
  logic [IDX_W-1:0] load_idx;
  logic [mpsr_pkg::ADDR_W-1:0] start;

  // Saturate the length to the window depth
  assign len_cfg = CMP_W'(cfg.pattern_length);
  assign len = (len_cfg > CMP_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_cfg[LEN_W-1:0];

  assign fill_next = item.region_start ? LEN_W'(1) :
                     (fill < LEN_W'(PATTERN_MAX)) ? fill + LEN_W'(1) : fill;

  always_comb begin
    window_next[0] = item.data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_next[j] = window[j-1];
    end
    // Oldest byte lowest, so the window start lands on lane 0 after the shift
    for (int k = 0; k < PATTERN_MAX; k++) begin
      rev[8*k +: 8] = window_next[PATTERN_MAX-1-k];
    end
  end

  assign shamt = LEN_W'(PATTERN_MAX) - len;
  assign aligned = rev >> {shamt, 3'b000};

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq[i] = pat_wild[i] | (pat_value[i] == aligned[8*i +: 8]);
      used[i] = LEN_W'(i) < len;
    end
  end

  assign window_match = (len != '0) && (fill_next >= len) && (&(eq | ~used));
  assign start = item.byte_address + mpsr_pkg::ADDR_W'(1) - mpsr_pkg::ADDR_W'(len);

  assign load_ok = int'(item.pattern_index) < PATTERN_MAX;
  assign load_idx = IDX_W'(item.pattern_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (take) begin
      case (item.mode)
        mpsr_pkg::MODE_SCAN: fill <= fill_next;
        mpsr_pkg::MODE_FINISH: fill <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (item.mode == mpsr_pkg::MODE_SCAN) begin
        window <= window_next;
      end
      if (item.mode == mpsr_pkg::MODE_LOAD && load_ok) begin
        pat_value[load_idx] <= item.data_byte;
        pat_wild[load_idx] <= item.wildcard_req;
      end
      mid.mode <= item.mode;
      mid.match <= (item.mode == mpsr_pkg::MODE_SCAN) && window_match;
      mid.start <= start;
    end
  end

endmodule

// ----- rtl/mpsr_run.sv -----
// Hit filtering, stride run tracking and finish resolution; registers the result word.
// Depends on mpsr_pkg for the match word, configuration and result types and codes.
`timescale 1ns / 1ps

module mpsr_run (
  input  logic clk,
  input  logic rst,
  input  mpsr_pkg::cfg_t cfg,
  input  logic take,
  input  mpsr_pkg::match_word_t mid,
  output mpsr_pkg::result_t result
);

  localparam int AW = mpsr_pkg::ADDR_W;
  localparam int CW = mpsr_pkg::COUNT_W;

  logic [AW-1:0] last_hit;
  logic [CW-1:0] hit_total;
  logic [AW-1:0] run_first;
  logic [CW-1:0] run_size;
  logic [1:0] long_runs;
  logic [AW-1:0] chosen_first;
  logic [CW-1:0] chosen_size;
  logic too_many;

  logic fresh;
  logic accept_hit;
  logic finish;
  logic [AW:0] next_addr;
  logic extend;
  logic run_long;
  logic take_chosen;
  logic [1:0] long_next;
  logic [AW-1:0] chosen_first_c;
  logic [CW-1:0] chosen_size_c;
  logic [CW-1:0] total_inc;
  logic [1:0] status;

  assign fresh = (hit_total == '0) || (mid.start > last_hit);
  assign accept_hit = (mid.mode == mpsr_pkg::MODE_SCAN) && mid.match && !too_many && fresh;
  assign finish = mid.mode == mpsr_pkg::MODE_FINISH;

  // A run continues only if the stride step stays inside the address space
  assign next_addr = {1'b0, last_hit} + (AW+1)'(cfg.run_spacing);
  assign extend = (run_size != '0) && !next_addr[AW] && (next_addr[AW-1:0] == mid.start);

  // Effect of closing the current run
  assign run_long = (run_size != '0) && (run_size >= CW'(cfg.run_target));
  assign take_chosen = run_long && (long_runs == 2'd0);
  assign long_next = (run_long && long_runs != 2'd3) ? long_runs + 2'd1 : long_runs;
  assign chosen_first_c = take_chosen ? run_first : chosen_first;
  assign chosen_size_c = take_chosen ? run_size : chosen_size;

  assign total_inc = hit_total + CW'(1);

  always_comb begin
    if (too_many) begin
      status = mpsr_pkg::ST_AMBIGUOUS;
    end else if (hit_total == '0 || long_next == 2'd0) begin
      status = mpsr_pkg::ST_UNRESOLVED;
    end else if (long_next == 2'd1 && chosen_size_c == CW'(cfg.run_target)) begin
      status = mpsr_pkg::ST_RESOLVED;
    end else begin
      status = mpsr_pkg::ST_AMBIGUOUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_hit <= '0;
      hit_total <= '0;
      run_first <= '0;
      run_size <= '0;
      long_runs <= '0;
      chosen_first <= '0;
      chosen_size <= '0;
      too_many <= 1'b0;
    end else if (take) begin
      if (finish) begin
        last_hit <= '0;
        hit_total <= '0;
        run_first <= '0;
        run_size <= '0;
        long_runs <= '0;
        chosen_first <= '0;
        chosen_size <= '0;
        too_many <= 1'b0;
      end else if (accept_hit) begin
        if (extend) begin
          run_size <= run_size + CW'(1);
        end else begin
          long_runs <= long_next;
          chosen_first <= chosen_first_c;
          chosen_size <= chosen_size_c;
          run_first <= mid.start;
          run_size <= CW'(1);
        end
        last_hit <= mid.start;
        hit_total <= total_inc;
        if (total_inc > CW'(cfg.hit_limit)) begin
          too_many <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.hit <= accept_hit;
      result.hit_address <= accept_hit ? mid.start : '0;
      result.final_status <= finish ? status : mpsr_pkg::ST_NONE;
      result.run_base <= (finish && status == mpsr_pkg::ST_RESOLVED) ? chosen_first_c : '0;
    end
  end

endmodule

// ----- rtl/masked_pattern_stride_run_scanner.sv -----
// Top level of the masked pattern stride run scanner: input register, pipeline control,
// match and run stages, configuration bank. Depends on mpsr_pkg, mpsr_cfg, mpsr_match, mpsr_run.
//
//   channel   direction  handshake                    word
//   item      in         item_valid / item_stall      mpsr_pkg::item_t
//   result    out        result_valid / result_stall  mpsr_pkg::result_t
//   config    in         psel / penable / pwrite      paddr, pwdata, prdata, pready
//
// One word in and one result word out per cycle when neither side stalls; a word passes
// the input register, the match register and the result register in turn. The window compare
// and the run update each sit in their own stage.
// Reset is synchronous and clears control state; there is no clearing pass.
// A stalled result holds its register while upstream stages keep filling bubbles.
`timescale 1ns / 1ps

module masked_pattern_stride_run_scanner #(
  parameter int PATTERN_MAX = mpsr_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  mpsr_pkg::item_t item,
  output logic result_valid,
  input  logic result_stall,
  output mpsr_pkg::result_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mpsr_pkg::PADDR_W-1:0] paddr,
  input  logic [mpsr_pkg::PDATA_W-1:0] pwdata,
  output logic [mpsr_pkg::PDATA_W-1:0] prdata,
  output logic pready
);

  mpsr_pkg::cfg_t cfg;
  mpsr_pkg::item_t in_word;
  mpsr_pkg::match_word_t mid;
  logic in_full;
  logic mid_full;
  logic out_full;
  logic out_free;
  logic mid_free;
  logic in_free;

  assign out_free = !out_full || !result_stall;
  assign mid_free = !mid_full || out_free;
  assign in_free = !in_full || mid_free;
  assign item_stall = !in_free;
  assign result_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mid_full <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (in_free) begin
        in_full <= item_valid;
      end
      if (mid_free) begin
        mid_full <= in_full;
      end
      if (out_free) begin
        out_full <= mid_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && item_valid) begin
      in_word <= item;
    end
  end

  mpsr_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  mpsr_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_match (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .take(in_full && mid_free),
    .item(in_word),
    .mid(mid)
  );

  mpsr_run u_run (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .take(mid_full && out_free),
    .mid(mid),
    .result(result)
  );

  // An accepted word always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> in_full)
    else $error("accepted item word not held in the input register");

  // A scan hit and a finish outcome never share one result word
  a_hit_or_finish: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.hit && result.final_status != mpsr_pkg::ST_NONE))
    else $error("result word carries both a hit and a finish outcome");

  // Run base only accompanies a resolved finish
  a_run_base: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.final_status != mpsr_pkg::ST_RESOLVED) |-> result.run_base == '0)
    else $error("run base set without a resolved outcome");

  // A full match stage with a free output moves on in the next cycle
  a_mid_advance: assert property (@(posedge clk) disable iff (rst)
    (mid_full && out_free) |=> out_full)
    else $error("match word lost on the way to the result register");

endmodule

// ----- sim/masked_pattern_stride_run_scanner_test.sv -----
// Self-checking bench for masked_pattern_stride_run_scanner: drives pattern, scan and finish
// words, predicts every result word in-bench and compares field by field. Depends on mpsr_pkg.
`timescale 1ns / 1ps

module masked_pattern_stride_run_scanner_test;

  localparam int PMAX = mpsr_pkg::PATTERN_MAX_DEFAULT;
  localparam int AW = mpsr_pkg::ADDR_W;
  localparam logic [AW-1:0] ADDR_TOP = '1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_BUDGET = 24;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  mpsr_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  mpsr_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mpsr_pkg::PADDR_W-1:0] paddr = '0;
  logic [mpsr_pkg::PDATA_W-1:0] pwdata = '0;
  logic [mpsr_pkg::PDATA_W-1:0] prdata;
  logic pready;

  masked_pattern_stride_run_scanner DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  mpsr_pkg::item_t pending_words[$];
  mpsr_pkg::result_t expected_results[$];
  mpsr_pkg::result_t want_result;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic receiver_held = 1'b0;
  event long_hold_go;

  // Scanner state as the block should hold it
  logic [5:0] cfg_len;
  logic [19:0] cfg_stride;
  logic [10:0] cfg_count;
  logic [10:0] cfg_max_hits;
  logic [7:0] pat_byte[PMAX];
  logic pat_wild[PMAX];
  logic [7:0] win[PMAX];
  int unsigned win_fill;
  logic [AW-1:0] last_hit;
  int unsigned hit_total;
  logic [AW-1:0] run_start;
  int unsigned run_len;
  int unsigned long_runs;
  logic [AW-1:0] pick_start;
  int unsigned pick_len;
  bit overflowed;

  // Pattern as the stimulus side has loaded it
  logic [7:0] plan_byte[PMAX];
  logic plan_wild[PMAX];

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void clear_scan_state();
    for (int i = 0; i < PMAX; i++) win[i] = '0;
    win_fill = 0;
    last_hit = '0;
    hit_total = 0;
    run_start = '0;
    run_len = 0;
    long_runs = 0;
    pick_start = '0;
    pick_len = 0;
    overflowed = 1'b0;
  endfunction

  function automatic void reset_scanner_model();
    cfg_len = mpsr_pkg::PATTERN_LENGTH_RESET;
    cfg_stride = mpsr_pkg::RUN_SPACING_RESET;
    cfg_count = mpsr_pkg::RUN_TARGET_RESET;
    cfg_max_hits = mpsr_pkg::HIT_LIMIT_RESET;
    for (int i = 0; i < PMAX; i++) begin
      pat_byte[i] = '0;
      pat_wild[i] = 1'b0;
    end
    clear_scan_state();
  endfunction

  // Remember the first long run; saturate the count at three
  function automatic void close_current_run();
    if (run_len > 0 && run_len >= cfg_count) begin
      if (long_runs == 0) begin
        pick_start = run_start;
        pick_len = run_len;
      end
      if (long_runs < 3) long_runs++;
    end
    run_len = 0;
  endfunction

  function automatic mpsr_pkg::result_t predict_scan_result(mpsr_pkg::item_t w);
    mpsr_pkg::result_t r;
    int unsigned len;
    bit match;
    logic [AW-1:0] start;
    logic [AW:0] next;
    r = '0;
    case (w.mode)
      mpsr_pkg::MODE_LOAD: begin
        pat_byte[w.pattern_index] = w.data_byte;
        pat_wild[w.pattern_index] = w.wildcard_req;
      end
      mpsr_pkg::MODE_SCAN: begin
        if (w.region_start) win_fill = 0;
        for (int i = PMAX - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = w.data_byte;
        if (win_fill < PMAX) win_fill++;
        len = (cfg_len > PMAX) ? PMAX : cfg_len;
        match = len > 0 && win_fill >= len;
        for (int i = 0; match && i < len; i++) begin
          if (!pat_wild[i] && pat_byte[i] != win[len-1-i]) match = 1'b0;
        end
        if (match && !overflowed) begin
          start = w.byte_address - AW'(len - 1);
          if (hit_total == 0 || start > last_hit) begin
            next = {1'b0, last_hit} + (AW+1)'(cfg_stride);
            r.hit = 1'b1;
            r.hit_address = start;
            if (run_len > 0 && !next[AW] && next[AW-1:0] == start) begin
              run_len++;
            end else begin
              close_current_run();
              run_start = start;
              run_len = 1;
            end
            last_hit = start;
            hit_total++;
            if (hit_total > cfg_max_hits) overflowed = 1'b1;
          end
        end
      end
      mpsr_pkg::MODE_FINISH: begin
        close_current_run();
        if (overflowed) begin
          r.final_status = mpsr_pkg::ST_AMBIGUOUS;
        end else if (hit_total == 0 || long_runs == 0) begin
          r.final_status = mpsr_pkg::ST_UNRESOLVED;
        end else if (long_runs == 1 && pick_len == cfg_count) begin
          r.final_status = mpsr_pkg::ST_RESOLVED;
          r.run_base = pick_start;
        end else begin
          r.final_status = mpsr_pkg::ST_AMBIGUOUS;
        end
        clear_scan_state();
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender: hold a stalled word, otherwise offer the next pending word or idle
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      reset_scanner_model();
    end else begin
      if (item_valid && !item_stall)
        expected_results.insert(expected_results.size(), predict_scan_result(item));
      if (!item_valid || !item_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_words.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected", 64'(result.final_status), '0);
        end else begin
          want_result = expected_results.pop_front();
          if (result.hit !== want_result.hit)
            report_mismatch("hit", 64'(result.hit), 64'(want_result.hit));
          if (result.hit_address !== want_result.hit_address)
            report_mismatch("hit_address", 64'(result.hit_address), 64'(want_result.hit_address));
          if (result.final_status !== want_result.final_status)
            report_mismatch("final_status", 64'(result.final_status),
                            64'(want_result.final_status));
          if (result.run_base !== want_result.run_base)
            report_mismatch("run_base", 64'(result.run_base), 64'(want_result.run_base));
        end
      end
      result_stall <= receiver_held || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off so that the pipeline backs up into the input
  always begin
    @(long_hold_go);
    @(posedge clk);
    receiver_held <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    receiver_held <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic apb_access(logic write, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= mpsr_pkg::PADDR_W'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(logic [1:0] idx, logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== want)
      report_mismatch($sformatf("register %0d readback", idx), 64'(got), 64'(want));
  endtask

  task automatic program_register(logic [1:0] idx, logic [31:0] value);
    logic [31:0] unused;
    logic [31:0] want;
    want = '0;
    case (idx)
      mpsr_pkg::REG_PATTERN_LENGTH: begin
        cfg_len = value[5:0];
        want = 32'(value[5:0]);
      end
      mpsr_pkg::REG_RUN_SPACING: begin
        cfg_stride = value[19:0];
        want = 32'(value[19:0]);
      end
      mpsr_pkg::REG_RUN_TARGET: begin
        cfg_count = value[10:0];
        want = 32'(value[10:0]);
      end
      default: begin
        cfg_max_hits = value[10:0];
        want = 32'(value[10:0]);
      end
    endcase
    apb_access(1'b1, idx, value, unused);
    check_register(idx, want);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || item_valid || expected_results.size() != 0);
  endtask

  // Drain, let the pipeline settle, reprogram, then return on a falling edge
  task automatic run_phase(int send_pct, int recv_pct, int len, int stride, int count,
                           int max_hits);
    wait_drained();
    repeat (4) @(posedge clk);
    program_register(mpsr_pkg::REG_PATTERN_LENGTH, 32'(len));
    program_register(mpsr_pkg::REG_RUN_SPACING, 32'(stride));
    program_register(mpsr_pkg::REG_RUN_TARGET, 32'(count));
    program_register(mpsr_pkg::REG_HIT_LIMIT, 32'(max_hits));
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    @(negedge clk);
  endtask

  function automatic logic [AW-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[AW-1:0];
  endfunction

  function automatic int unsigned pattern_span();
    return (cfg_len > PMAX) ? PMAX : cfg_len;
  endfunction

  function automatic void queue_word(logic [1:0] mode, logic [4:0] idx, logic [7:0] data,
                                     logic wild, logic [AW-1:0] addr, logic region);
    mpsr_pkg::item_t w;
    w.mode = mode;
    w.pattern_index = idx;
    w.data_byte = data;
    w.wildcard_req = wild;
    w.byte_address = addr;
    w.region_start = region;
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void queue_load(logic [4:0] idx, logic [7:0] data, logic wild);
    plan_byte[idx] = data;
    plan_wild[idx] = wild;
    queue_word(mpsr_pkg::MODE_LOAD, idx, data, wild, rand_addr(), 1'($urandom));
  endfunction

  function automatic void queue_scan(logic [AW-1:0] addr, logic [7:0] data, logic region);
    queue_word(mpsr_pkg::MODE_SCAN, 5'($urandom), data, 1'($urandom), addr, region);
  endfunction

  function automatic void queue_finish();
    queue_word(mpsr_pkg::MODE_FINISH, 5'($urandom), 8'($urandom), 1'($urandom), rand_addr(),
               1'($urandom));
  endfunction

  function automatic void queue_new_pattern(int wild_pct);
    for (int i = 0; i < PMAX; i++)
      queue_load(5'(i), 8'($urandom), $urandom_range(99) < wild_pct);
  endfunction

  // One copy of the pattern, wildcards filled at random, now and then spoilt
  function automatic logic [AW-1:0] queue_copy(logic [AW-1:0] addr, logic region);
    int unsigned len;
    int unsigned spoil;
    logic [7:0] b;
    len = pattern_span();
    spoil = ($urandom_range(19) == 0) ? $urandom_range(len - 1) : len;
    for (int i = 0; i < len; i++) begin
      b = plan_wild[i] ? 8'($urandom) : plan_byte[i];
      if (i == spoil) b = b ^ 8'($urandom_range(1, 255));
      queue_scan(addr + AW'(i), b, region && i == 0);
    end
    return addr + AW'(len);
  endfunction

  // Copies at the run spacing: back to back with filler where the spacing
  // allows it, else each copy in a region of its own
  function automatic logic [AW-1:0] queue_run_job(logic [AW-1:0] base, int copies, bit fresh);
    int unsigned len;
    bit split;
    logic [AW-1:0] a;
    len = pattern_span();
    if (len == 0) begin
      for (int i = 0; i < 6; i++) queue_scan(base + AW'(i), 8'($urandom), fresh && i == 0);
      return base + AW'(6);
    end
    split = cfg_stride < len || cfg_stride - len > 24;
    a = base;
    for (int k = 0; k < copies; k++) begin
      if (split) begin
        a = queue_copy(base + AW'(k) * AW'(cfg_stride), 1'b1);
        repeat ($urandom_range(3)) begin
          queue_scan(a, 8'($urandom), 1'b0);
          a = a + AW'(1);
        end
      end else begin
        a = queue_copy(a, fresh && k == 0);
        repeat (cfg_stride - len) begin
          queue_scan(a, 8'($urandom), 1'b0);
          a = a + AW'(1);
        end
      end
    end
    return a;
  endfunction

  function automatic void queue_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(2))
        0: queue_word(MODE_UNUSED, 5'($urandom), 8'($urandom), 1'($urandom), rand_addr(),
                      1'($urandom));
        1: queue_scan(rand_addr(), 8'($urandom), 1'($urandom));
        default: queue_load(5'($urandom), 8'($urandom), $urandom_range(3) == 0);
      endcase
    end
  endfunction

  // Scans built around the required run length in copies, some with a second
  // stretch that may fall below the last hit, each closed by a finish
  function automatic void queue_scans(int budget);
    int target;
    int copies;
    logic [AW-1:0] a;
    target = pending_words.size() + budget;
    while (pending_words.size() < target) begin
      a = ($urandom_range(5) == 0) ? ADDR_TOP - AW'($urandom_range(80)) : rand_addr();
      case ($urandom_range(3))
        0, 1: copies = cfg_count;
        2: copies = cfg_count + 1;
        default: copies = $urandom_range(4);
      endcase
      if (copies > 6) copies = $urandom_range(1, 6);
      a = queue_run_job(a, copies, 1'b1);
      if ($urandom_range(3) == 0) begin
        a = ($urandom_range(2) == 0) ? rand_addr() : a + AW'($urandom_range(40));
        a = queue_run_job(a, $urandom_range(1, 3), 1'b1);
      end
      if ($urandom_range(4) == 0) queue_noise();
      queue_finish();
    end
  endfunction

  initial begin
    int unsigned plen;
    logic [AW-1:0] a;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    check_register(mpsr_pkg::REG_PATTERN_LENGTH, 32'(mpsr_pkg::PATTERN_LENGTH_RESET));
    check_register(mpsr_pkg::REG_RUN_SPACING, 32'(mpsr_pkg::RUN_SPACING_RESET));
    check_register(mpsr_pkg::REG_RUN_TARGET, 32'(mpsr_pkg::RUN_TARGET_RESET));
    check_register(mpsr_pkg::REG_HIT_LIMIT, 32'(mpsr_pkg::HIT_LIMIT_RESET));

    // Two-byte pattern: exact 0xFF then a wildcard, runs at stride 1
    run_phase(18, 64, 2, 1, 2, 1024);
    queue_load(5'd0, 8'hFF, 1'b0);
    queue_load(5'd1, 8'h00, 1'b1);
    queue_load(5'd31, 8'hFF, 1'b0);
    queue_word(MODE_UNUSED, 5'h1F, 8'hFF, 1'b1, ADDR_TOP, 1'b1);
    queue_finish();
    // run of two from address zero
    queue_scan('0, 8'hFF, 1'b1);
    queue_scan(AW'(1), 8'hFF, 1'b0);
    queue_scan(AW'(2), 8'h00, 1'b0);
    queue_scan(AW'(3), 8'h12, 1'b0);
    queue_finish();
    // start address wraps to the top; the later, lower match is dropped
    queue_scan(ADDR_TOP, 8'hFF, 1'b1);
    queue_scan('0, 8'h55, 1'b0);
    queue_scan(AW'(1), 8'hFF, 1'b0);
    queue_scan(AW'(2), 8'h00, 1'b0);
    queue_finish();
    // region start empties the window
    queue_scan(AW'(100), 8'hFF, 1'b1);
    queue_scan(AW'(101), 8'hFF, 1'b1);
    queue_scan(AW'(102), 8'h01, 1'b0);
    queue_scan(AW'(103), 8'hFF, 1'b0);
    queue_finish();
    // run of three where two are required
    for (int i = 0; i < 4; i++) queue_scan(AW'(200 + i), 8'hFF, i == 0);
    queue_finish();

    run_phase(18, 64, 16, 16, 3, 1024);
    queue_new_pattern(20);
    queue_scans(PHASE_BUDGET);

    // pause mid-scan until every result is back, then finish the run
    run_phase(18, 64, 32, 40, 1, 1024);
    a = queue_run_job(rand_addr(), 2, 1'b1);
    wait_drained();
    a = queue_run_job(a, 1, 1'b0);
    queue_finish();
    queue_scans(PHASE_BUDGET);

    plen = $urandom_range(20, 32);
    run_phase(18, 64, plen, plen + $urandom_range(8), 2, 1024);
    -> long_hold_go;
    queue_new_pattern(25);
    queue_scans(PHASE_BUDGET);

    // hit overflow
    run_phase(64, 18, 16, 16, 2, 2);
    queue_scans(PHASE_BUDGET);

    // empty pattern, zero stride, widest counts
    run_phase(64, 18, 0, 0, 2047, 2047);
    queue_scans(PHASE_BUDGET);

    // length saturates, widest stride
    run_phase(64, 18, 63, 1048575, 1024, 1);
    queue_new_pattern(15);
    queue_scans(PHASE_BUDGET);

    // zero required run length
    run_phase(0, 0, 17, 17, 0, 1023);
    queue_scans(PHASE_BUDGET);

    run_phase(0, 0, 24, 1000, 2, 5);
    queue_scans(PHASE_BUDGET);

    plen = $urandom_range(16, 32);
    run_phase(0, 0, plen, $urandom_range(1, 64), $urandom_range(1, 4), 1024);
    queue_new_pattern(30);
    queue_scans(PHASE_BUDGET);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- masked_pattern_stride_run_scanner.f -----
rtl/mpsr_pkg.sv
rtl/mpsr_cfg.sv
rtl/mpsr_match.sv
rtl/mpsr_run.sv
rtl/masked_pattern_stride_run_scanner.sv
sim/masked_pattern_stride_run_scanner_test.sv
